// ===== hw/rtl/fzw_pkg.sv =====
// ----------------------------------------------------------------------------
// fzw_pkg: shared constants and types for the fuzzy wheel speed block
// Breakpoints, reciprocal constants, rule consequent tables, stage map and
// the structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fzw_pkg;

  // stage map: grading 0..2, rules 3..8, divider 9..16, output 17
  localparam int NS       = 18;
  localparam int ST_GRADE = 0;
  localparam int ST_RULE  = 3;
  localparam int ST_DIV   = 9;
  localparam int DIV_ST   = 8;
  localparam int ST_OUT   = 17;

  // widths
  localparam int DW     = 16;  // distance and speed fields
  localparam int MW     = 17;  // membership / strength, Q1.16 up to 1.0
  localparam int OW     = 13;  // ramp offset
  localparam int RW     = 25;  // reciprocal
  localparam int PSUM_W = 21;  // partial sum of nine strengths
  localparam int DEN_W  = 22;  // sum of strengths
  localparam int PW     = 39;  // sum times level
  localparam int NUM_W  = 41;  // signed numerator
  localparam int MAG_W  = 40;  // numerator magnitude

  localparam logic [MW-1:0] ONE_Q16 = 17'h10000;

  // breakpoints per sensor: left, front, right
  localparam logic [DW-1:0] BP_A [3] = '{16'd500, 16'd600, 16'd500};
  localparam logic [DW-1:0] BP_B [3] = '{16'd650, 16'd750, 16'd650};
  localparam logic [DW-1:0] BP_C [3] = '{16'd750, 16'd850, 16'd750};
  localparam logic [DW-1:0] BP_D [3] = '{16'd900, 16'd1000, 16'd900};
  localparam logic [DW-1:0] BP_FAR = 16'd5000;

  // ramp spans and floor(2^32 / span); the far span differs per sensor
  localparam logic [OW-1:0] SPAN_NEAR     = 13'd150;
  localparam logic [OW-1:0] SPAN_FAR [3]  = '{13'd4250, 13'd4150, 13'd4250};
  localparam logic [RW-1:0] RECIP_NEAR    = 25'd28633115;
  localparam logic [RW-1:0] RECIP_FAR [3] = '{25'd1010580, 25'd1034931, 25'd1010580};

  // membership term kinds
  localparam logic [1:0] MK_ZERO = 2'd0;
  localparam logic [1:0] MK_ONE  = 2'd1;
  localparam logic [1:0] MK_RAMP = 2'd2;

  // speed level codes
  localparam logic [1:0] LV_S = 2'd0;
  localparam logic [1:0] LV_M = 2'd1;
  localparam logic [1:0] LV_F = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOW   = 2'd0;
  localparam logic [1:0] CFG_MEDIUM = 2'd1;
  localparam logic [1:0] CFG_FAST   = 2'd2;

  // consequents, rule = left_grade * 9 + front_grade * 3 + right_grade
  localparam logic [1:0] LEFT_RULE [27] = '{
    LV_S, LV_F, LV_F, LV_S, LV_F, LV_M, LV_S, LV_M, LV_M,
    LV_S, LV_S, LV_F, LV_S, LV_M, LV_M, LV_S, LV_F, LV_F,
    LV_S, LV_S, LV_S, LV_S, LV_F, LV_F, LV_S, LV_F, LV_F
  };
  localparam logic [1:0] RIGHT_RULE [27] = '{
    LV_F, LV_S, LV_S, LV_F, LV_S, LV_S, LV_F, LV_S, LV_S,
    LV_F, LV_F, LV_S, LV_M, LV_M, LV_M, LV_F, LV_F, LV_F,
    LV_F, LV_F, LV_F, LV_M, LV_F, LV_F, LV_M, LV_F, LV_F
  };

  typedef logic [NS-1:0] stage_en_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic          far;
    logic [OW-1:0] off;
  } mterm_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_l;
    logic [MAG_W-1:0] mag_r;
    logic             neg_l;
    logic             neg_r;
    logic [DEN_W-1:0] den;
  } quot_req_t;

  typedef struct packed {
    logic [DW-1:0] qmag_l;
    logic [DW-1:0] qmag_r;
    logic          neg_l;
    logic          neg_r;
    logic          zero;
  } quot_res_t;

endpackage

// ===== hw/rtl/fzw_grade.sv =====
// ----------------------------------------------------------------------------
// fzw_grade: membership grading of the three distances
// Three stages: region decode, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fzw_grade (
  input  logic                                     clk,
  input  fzw_pkg::stage_en_t                       en,
  input  logic [2:0][fzw_pkg::DW-1:0]              distance,
  output logic [2:0][2:0][fzw_pkg::MW-1:0]         grade
);

  fzw_pkg::mterm_t                term0 [3][3];
  fzw_pkg::mterm_t                term  [3][3];
  fzw_pkg::mterm_t                term1 [3][3];
  logic [fzw_pkg::MW-1:0]         q0    [3][3];

  // region decode and ramp offsets
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      logic [fzw_pkg::DW-1:0] x;
      x = distance[s];
      // low: falling ramp
      term[s][0].far = 1'b0;
      term[s][0].off = '0;
      if (x <= fzw_pkg::BP_A[s]) begin
        term[s][0].kind = fzw_pkg::MK_ONE;
      end else if (x >= fzw_pkg::BP_B[s]) begin
        term[s][0].kind = fzw_pkg::MK_ZERO;
      end else begin
        term[s][0].kind = fzw_pkg::MK_RAMP;
        term[s][0].off  = fzw_pkg::OW'(fzw_pkg::BP_B[s] - x);
      end
      // mid: trapezoid
      term[s][1].far = 1'b0;
      term[s][1].off = '0;
      if (x <= fzw_pkg::BP_A[s] || x >= fzw_pkg::BP_D[s]) begin
        term[s][1].kind = fzw_pkg::MK_ZERO;
      end else if (x < fzw_pkg::BP_B[s]) begin
        term[s][1].kind = fzw_pkg::MK_RAMP;
        term[s][1].off  = fzw_pkg::OW'(x - fzw_pkg::BP_A[s]);
      end else if (x <= fzw_pkg::BP_C[s]) begin
        term[s][1].kind = fzw_pkg::MK_ONE;
      end else begin
        term[s][1].kind = fzw_pkg::MK_RAMP;
        term[s][1].off  = fzw_pkg::OW'(fzw_pkg::BP_D[s] - x);
      end
      // high: long rising ramp
      term[s][2].far = 1'b1;
      term[s][2].off = '0;
      if (x <= fzw_pkg::BP_C[s]) begin
        term[s][2].kind = fzw_pkg::MK_ZERO;
      end else if (x >= fzw_pkg::BP_FAR) begin
        term[s][2].kind = fzw_pkg::MK_ONE;
      end else begin
        term[s][2].kind = fzw_pkg::MK_RAMP;
        term[s][2].off  = fzw_pkg::OW'(x - fzw_pkg::BP_C[s]);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < 3; s++) begin
      for (int g = 0; g < 3; g++) begin
        logic [fzw_pkg::OW+fzw_pkg::RW-1:0] prod;
        logic [fzw_pkg::MW+fzw_pkg::OW-1:0] back;
        logic [fzw_pkg::MW+fzw_pkg::OW-1:0] rem;
        logic [fzw_pkg::OW-1:0]             span;
        // region decode
        if (en[fzw_pkg::ST_GRADE]) begin
          term0[s][g] <= term[s][g];
        end
        // estimate off * 2^16 / span from below
        if (en[fzw_pkg::ST_GRADE+1]) begin
          prod = term0[s][g].off *
                 (term0[s][g].far ? fzw_pkg::RECIP_FAR[s] : fzw_pkg::RECIP_NEAR);
          q0[s][g]    <= prod[16 +: fzw_pkg::MW];
          term1[s][g] <= term0[s][g];
        end
        // one correction step
        if (en[fzw_pkg::ST_GRADE+2]) begin
          span = term1[s][g].far ? fzw_pkg::SPAN_FAR[s] : fzw_pkg::SPAN_NEAR;
          back = q0[s][g] * span;
          rem  = {1'b0, term1[s][g].off, 16'h0000} - back;
          unique case (term1[s][g].kind)
            fzw_pkg::MK_ONE:  grade[s][g] <= fzw_pkg::ONE_Q16;
            fzw_pkg::MK_RAMP: grade[s][g] <= (rem >= fzw_pkg::MW'(span)) ?
                                             q0[s][g] + 1'b1 : q0[s][g];
            default:          grade[s][g] <= '0;
          endcase
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fzw_rules.sv =====
// ----------------------------------------------------------------------------
// fzw_rules: rule strengths and weighted sums
// Six stages: pair products, rule strengths, partial sums, totals, level
// products, numerator sum with sign split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fzw_rules (
  input  logic                                  clk,
  input  fzw_pkg::stage_en_t                    en,
  input  logic [2:0][2:0][fzw_pkg::MW-1:0]      grade,
  input  logic signed [fzw_pkg::DW-1:0]         level [3],
  output fzw_pkg::quot_req_t                    req
);

  logic [fzw_pkg::MW-1:0]     lf      [3][3];
  logic [fzw_pkg::MW-1:0]     gr1     [3];
  logic [fzw_pkg::MW-1:0]     strength[27];
  logic [fzw_pkg::PSUM_W-1:0] pden    [3];
  logic [fzw_pkg::PSUM_W-1:0] pl      [3][3];
  logic [fzw_pkg::PSUM_W-1:0] pr      [3][3];
  logic [fzw_pkg::DEN_W-1:0]  den4;
  logic [fzw_pkg::DEN_W-1:0]  sl      [3];
  logic [fzw_pkg::DEN_W-1:0]  sr      [3];
  logic [fzw_pkg::DEN_W-1:0]  den5;
  logic signed [fzw_pkg::PW-1:0] ml   [3];
  logic signed [fzw_pkg::PW-1:0] mr   [3];

  always_ff @(posedge clk) begin
    logic [2*fzw_pkg::MW-1:0]   p;
    logic [fzw_pkg::PSUM_W-1:0] a_den;
    logic [fzw_pkg::PSUM_W-1:0] a_l [3];
    logic [fzw_pkg::PSUM_W-1:0] a_r [3];
    logic [fzw_pkg::DEN_W-1:0]  t_den;
    logic [fzw_pkg::DEN_W-1:0]  t_l;
    logic [fzw_pkg::DEN_W-1:0]  t_r;
    logic signed [fzw_pkg::NUM_W-1:0] nl;
    logic signed [fzw_pkg::NUM_W-1:0] nr;
    // left times front
    if (en[fzw_pkg::ST_RULE]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p = grade[0][i] * grade[1][j];
          lf[i][j] <= p[16 +: fzw_pkg::MW];
        end
        gr1[i] <= grade[2][i];
      end
    end
    // times right
    if (en[fzw_pkg::ST_RULE+1]) begin
      for (int r = 0; r < 27; r++) begin
        p = lf[r/9][(r/3)%3] * gr1[r%3];
        strength[r] <= p[16 +: fzw_pkg::MW];
      end
    end
    // partial sums per left grade
    if (en[fzw_pkg::ST_RULE+2]) begin
      for (int i = 0; i < 3; i++) begin
        a_den = '0;
        for (int c = 0; c < 3; c++) begin
          a_l[c] = '0;
          a_r[c] = '0;
        end
        for (int m = 0; m < 9; m++) begin
          a_den = a_den + strength[i*9+m];
          for (int c = 0; c < 3; c++) begin
            if (fzw_pkg::LEFT_RULE[i*9+m] == 2'(c)) begin
              a_l[c] = a_l[c] + strength[i*9+m];
            end
            if (fzw_pkg::RIGHT_RULE[i*9+m] == 2'(c)) begin
              a_r[c] = a_r[c] + strength[i*9+m];
            end
          end
        end
        pden[i] <= a_den;
        for (int c = 0; c < 3; c++) begin
          pl[i][c] <= a_l[c];
          pr[i][c] <= a_r[c];
        end
      end
    end
    // totals
    if (en[fzw_pkg::ST_RULE+3]) begin
      t_den = '0;
      for (int i = 0; i < 3; i++) begin
        t_den = t_den + pden[i];
      end
      den4 <= t_den;
      for (int c = 0; c < 3; c++) begin
        t_l = '0;
        t_r = '0;
        for (int i = 0; i < 3; i++) begin
          t_l = t_l + pl[i][c];
          t_r = t_r + pr[i][c];
        end
        sl[c] <= t_l;
        sr[c] <= t_r;
      end
    end
    // level products
    if (en[fzw_pkg::ST_RULE+4]) begin
      for (int c = 0; c < 3; c++) begin
        ml[c] <= $signed({1'b0, sl[c]}) * level[c];
        mr[c] <= $signed({1'b0, sr[c]}) * level[c];
      end
      den5 <= den4;
    end
    // numerators, split into sign and magnitude
    if (en[fzw_pkg::ST_RULE+5]) begin
      nl = fzw_pkg::NUM_W'(ml[0]) + fzw_pkg::NUM_W'(ml[1]) + fzw_pkg::NUM_W'(ml[2]);
      nr = fzw_pkg::NUM_W'(mr[0]) + fzw_pkg::NUM_W'(mr[1]) + fzw_pkg::NUM_W'(mr[2]);
      req.neg_l <= nl[fzw_pkg::NUM_W-1];
      req.neg_r <= nr[fzw_pkg::NUM_W-1];
      req.mag_l <= fzw_pkg::MAG_W'(nl[fzw_pkg::NUM_W-1] ? -nl : nl);
      req.mag_r <= fzw_pkg::MAG_W'(nr[fzw_pkg::NUM_W-1] ? -nr : nr);
      req.den   <= den5;
    end
  end

endmodule

// ===== hw/rtl/fzw_div.sv =====
// ----------------------------------------------------------------------------
// fzw_div: pipelined restoring divider for both wheels
// Eight stages, two quotient bits per stage, shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fzw_div (
  input  logic                clk,
  input  fzw_pkg::stage_en_t  en,
  input  fzw_pkg::quot_req_t  req,
  output fzw_pkg::quot_res_t  res
);

  logic [fzw_pkg::MAG_W-1:0] rem  [fzw_pkg::DIV_ST+1][2];
  logic [fzw_pkg::DW-1:0]    quo  [fzw_pkg::DIV_ST+1][2];
  logic [fzw_pkg::DEN_W-1:0] den  [fzw_pkg::DIV_ST+1];
  logic                      neg  [fzw_pkg::DIV_ST+1][2];

  // stage zero view of the request
  assign rem[0][0] = req.mag_l;
  assign rem[0][1] = req.mag_r;
  assign quo[0][0] = '0;
  assign quo[0][1] = '0;
  assign den[0]    = req.den;
  assign neg[0][0] = req.neg_l;
  assign neg[0][1] = req.neg_r;

  for (genvar k = 0; k < fzw_pkg::DIV_ST; k++) begin : g_st
    always_ff @(posedge clk) begin
      logic [fzw_pkg::MAG_W-1:0] r;
      logic [fzw_pkg::DW-1:0]    q;
      logic [fzw_pkg::MAG_W-1:0] d;
      if (en[fzw_pkg::ST_DIV+k]) begin
        for (int w = 0; w < 2; w++) begin
          r = rem[k][w];
          q = quo[k][w];
          for (int t = 0; t < 2; t++) begin
            d = fzw_pkg::MAG_W'(den[k]) << (fzw_pkg::DW - 1 - 2*k - t);
            if (r >= d) begin
              r = r - d;
              q[fzw_pkg::DW-1-2*k-t] = 1'b1;
            end
          end
          rem[k+1][w] <= r;
          quo[k+1][w] <= q;
          neg[k+1][w] <= neg[k][w];
        end
        den[k+1] <= den[k];
      end
    end
  end

  assign res.qmag_l = quo[fzw_pkg::DIV_ST][0];
  assign res.qmag_r = quo[fzw_pkg::DIV_ST][1];
  assign res.neg_l  = neg[fzw_pkg::DIV_ST][0];
  assign res.neg_r  = neg[fzw_pkg::DIV_ST][1];
  assign res.zero   = (den[fzw_pkg::DIV_ST] == '0);

endmodule

// ===== hw/rtl/fuzzy_three_sensor_wheel_speed.sv =====
// ----------------------------------------------------------------------------
// fuzzy_three_sensor_wheel_speed: three-sensor fuzzy wheel speed controller
// Grades three distances, forms 27 rule strengths and divides the weighted
// sums of the configured speed levels into two wheel speeds.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while results are taken or bubbles remain, set by the 18-stage pipeline
// stalls fill bubbles first; s_tready drops only when all 18 stages are full
// reset: synchronous rst clears stage valid bits and the three speed levels
// configuration writes are taken every cycle (cfg_ready tied high)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuzzy_three_sensor_wheel_speed (
  input  logic        clk,
  input  logic        rst,
  // request: left_distance, front_distance, right_distance
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  // result: left_wheel_speed, right_wheel_speed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fzw_pkg::stage_en_t                     en;
  logic [fzw_pkg::NS-1:0]                 v;
  logic signed [fzw_pkg::DW-1:0]          level [3];
  logic [2:0][fzw_pkg::DW-1:0]            distance;
  logic [2:0][2:0][fzw_pkg::MW-1:0]       grade;
  fzw_pkg::quot_req_t                     req;
  fzw_pkg::quot_res_t                     res;
  logic [fzw_pkg::DW-1:0]                 q_l;
  logic [fzw_pkg::DW-1:0]                 q_r;

  // stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    en[fzw_pkg::NS-1] = !v[fzw_pkg::NS-1] || m_tready;
    for (int s = fzw_pkg::NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[fzw_pkg::NS-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < fzw_pkg::NS; s++) begin
        if (en[s]) begin
          v[s] <= (s == 0) ? s_tvalid : v[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  // speed level registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level[0] <= '0;
      level[1] <= '0;
      level[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fzw_pkg::CFG_SLOW:   level[0] <= cfg_data;
        fzw_pkg::CFG_MEDIUM: level[1] <= cfg_data;
        fzw_pkg::CFG_FAST:   level[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // distance unpacking
  assign distance[0] = s_tdata[15:0];
  assign distance[1] = s_tdata[31:16];
  assign distance[2] = s_tdata[47:32];

  fzw_grade u_grade (
    .clk      (clk),
    .en       (en),
    .distance (distance),
    .grade    (grade)
  );

  fzw_rules u_rules (
    .clk   (clk),
    .en    (en),
    .grade (grade),
    .level (level),
    .req   (req)
  );

  fzw_div u_div (
    .clk (clk),
    .en  (en),
    .req (req),
    .res (res)
  );

  // sign restore and output register
  assign q_l = res.zero ? '0 : (res.neg_l ? -res.qmag_l : res.qmag_l);
  assign q_r = res.zero ? '0 : (res.neg_r ? -res.qmag_r : res.qmag_r);

  always_ff @(posedge clk) begin
    if (en[fzw_pkg::ST_OUT]) begin
      m_tdata <= {q_r, q_l};
    end
  end

`ifndef SYNTHESIS
  // back pressure only when the whole pipeline is full and stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&v) && !m_tready)
    else $error("input stalled with room in the pipeline");

  // an accepted request occupies the first stage
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[0])
    else $error("accepted request lost at pipeline entry");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("valid bits survive reset");

  // a stalled result stays valid
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("pending result dropped");
`endif

endmodule
